/* design/fpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO page replacement - shared types and constants
// Address, word and page widths, access codes.
// ----------------------------------------------------------------------------
package fpr_pkg;

	localparam int ADDR_W      = 10;
	localparam int WORD_W      = 32;
	localparam int PAGE_WORDS  = 16;
	localparam int PAGE_SHIFT  = $clog2(PAGE_WORDS);
	localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
	localparam int STORE_WORDS = 1 << ADDR_W;

	typedef logic               op_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [PAGE_W-1:0]  page_t;

	localparam op_t OP_READ  = 1'b0;
	localparam op_t OP_WRITE = 1'b1;

endpackage
`default_nettype wire

/* design/fpr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO page replacement - channel interfaces
// Access request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpr_req_if;
	logic           valid;
	logic           ready;
	fpr_pkg::op_t   op;
	fpr_pkg::addr_t addr;
	fpr_pkg::word_t wdata;

	modport source (output valid, output op, output addr, output wdata, input ready);
	modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

interface fpr_rsp_if;
	logic           valid;
	logic           ready;
	fpr_pkg::word_t rdata;
	logic           fault;
	logic           replaced;
	fpr_pkg::page_t evicted_page;

	modport source (output valid, output rdata, output fault, output replaced,
		output evicted_page, input ready);
	modport sink   (input valid, input rdata, input fault, input replaced,
		input evicted_page, output ready);
endinterface
`default_nettype wire

/* design/fifo_page_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO page replacement
// Checks the page of each access against the resident tags, loads it on a
// fault and evicts the oldest resident page once all slots are taken.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | op, addr, wdata
//  rsp     | out | rdata, fault, replaced, evicted_page
//
// One access per cycle while not clearing and no result stalls; the result is
// shown the cycle after acceptance. The word store port (one read or write
// per cycle) sets the rate. After reset the word store is cleared, one word
// per cycle over all 1024 words, during which req.ready stays low.
// A stalled result holds; a new transaction is taken in the cycle it leaves.
module fifo_page_replacement #(
	parameter int RESIDENT_PAGES = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	fpr_req_if.sink     req,
	fpr_rsp_if.source   rsp
);
	import fpr_pkg::*;

	localparam int CNT_W  = $clog2(RESIDENT_PAGES + 1);
	localparam int SLOT_W = (RESIDENT_PAGES > 1) ? $clog2(RESIDENT_PAGES) : 1;
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(RESIDENT_PAGES);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RESIDENT_PAGES - 1);

	page_t             tags_q [RESIDENT_PAGES];
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] oldest_q;

	word_t             mem [STORE_WORDS];
	word_t             rd_q;
	logic              clr_busy_q;
	addr_t             clr_idx_q;

	logic              out_valid_q;
	logic              wr_q;
	logic              fault_q;
	logic              replaced_q;
	page_t             evicted_q;

	logic              accept;
	page_t             page;
	logic              hit;
	logic              full;
	logic [SLOT_W-1:0] fill_slot;
	page_t             victim;

	assign req.ready = !clr_busy_q && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign page      = req.addr[ADDR_W-1:PAGE_SHIFT];
	assign full      = (count_q == CNT_FULL);
	assign fill_slot = count_q[SLOT_W-1:0];
	assign victim    = tags_q[oldest_q];

	always_comb begin
		hit = 1'b0;
		for (int s = 0; s < RESIDENT_PAGES; s++) begin
			if ((count_q > CNT_W'(s)) && (tags_q[s] == page)) begin
				hit = 1'b1;
			end
		end
	end

	// tag slots: fill the next free slot, else overwrite the oldest
	always_ff @(posedge clk) begin
		if (accept && !hit) begin
			for (int s = 0; s < RESIDENT_PAGES; s++) begin
				if (full ? (oldest_q == SLOT_W'(s)) : (fill_slot == SLOT_W'(s))) begin
					tags_q[s] <= page;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
		end else if (accept && !hit) begin
			if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (oldest_q == SLOT_LAST) begin
				oldest_q <= '0;
			end else begin
				oldest_q <= oldest_q + SLOT_W'(1);
			end
		end
	end

	// word store: clearing sweep after reset, then one access per transaction
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (accept && req.op == OP_WRITE) begin
			mem[req.addr] <= req.wdata;
		end
		if (accept && req.op == OP_READ) begin
			rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + ADDR_W'(1);
			if (clr_idx_q == ADDR_W'(STORE_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_q       <= (req.op == OP_WRITE);
			fault_q    <= !hit;
			replaced_q <= !hit && full;
			evicted_q  <= (!hit && full) ? victim : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.rdata        = wr_q ? '0 : rd_q;
	assign rsp.fault        = fault_q;
	assign rsp.replaced     = replaced_q;
	assign rsp.evicted_page = evicted_q;

endmodule
`default_nettype wire

/* test/fifo_page_replacement_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement - testbench
// Drives read and write accesses through the request channel and keeps its
// own copy of the resident tags, the FIFO pointer and the word store.
// Results are checked field by field, in order, against that copy, under
// sender gaps, receiver stalls, a long hold-off and a full drain.
// ----------------------------------------------------------------------------
module fifo_page_replacement_tb;
	import fpr_pkg::*;

	localparam int RESIDENT_PAGES = 4;
	localparam int STALL_LIMIT    = 5000;
	localparam int HOT_PAGES      = 6;

	typedef struct packed {
		word_t rdata;
		logic  fault;
		logic  replaced;
		page_t evicted_page;
	} access_result_t;

	logic clk;
	logic arst_n;

	fpr_req_if req_ch ();
	fpr_rsp_if rsp_ch ();

	fifo_page_replacement #(
		.RESIDENT_PAGES(RESIDENT_PAGES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Mirror of the block state
	page_t resident_tag [RESIDENT_PAGES];
	int    resident_cnt;
	int    oldest_slot;
	word_t word_mirror [STORE_WORDS];

	access_result_t pending_results [$];
	page_t          hot_page [HOT_PAGES];

	int send_idle_pct;
	int recv_stall_pct;
	int holdoff_left;
	int mismatches;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic access_result_t predict_access(op_t kind, addr_t a, word_t data);
		access_result_t r;
		page_t          pg;
		logic           hit;
		r   = '0;
		pg  = page_t'(a >> PAGE_SHIFT);
		hit = 1'b0;
		for (int s = 0; s < resident_cnt; s++)
			if (resident_tag[s] == pg)
				hit = 1'b1;
		if (!hit) begin
			r.fault = 1'b1;
			if (resident_cnt < RESIDENT_PAGES) begin
				resident_tag[resident_cnt] = pg;
				resident_cnt++;
			end else begin
				// evict the page resident longest
				r.replaced     = 1'b1;
				r.evicted_page = resident_tag[oldest_slot];
				resident_tag[oldest_slot] = pg;
				oldest_slot = (oldest_slot + 1) % RESIDENT_PAGES;
			end
		end
		if (kind == OP_WRITE)
			word_mirror[a] = data;
		else
			r.rdata = word_mirror[a];
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %h, got %h", $realtime, name, want, got);
		end
	endfunction

	task automatic send_access(op_t kind, addr_t a, word_t data);
		access_result_t exp_r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= kind;
		req_ch.addr  <= a;
		req_ch.wdata <= data;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		exp_r = predict_access(kind, a, data);
		pending_results = {pending_results, exp_r};
	endtask

	task automatic send_random_access();
		page_t pg;
		addr_t a;
		word_t data;
		op_t   kind;
		// keep a small working set so hits and evictions both show up
		if ($urandom_range(99) < 5)
			hot_page[$urandom_range(HOT_PAGES - 1)] = page_t'($urandom());
		if ($urandom_range(99) < 80)
			pg = hot_page[$urandom_range(HOT_PAGES - 1)];
		else
			pg = page_t'($urandom());
		a    = {pg, PAGE_SHIFT'($urandom())};
		kind = op_t'($urandom_range(1));
		case ($urandom_range(9))
			0: data = 32'sh7fffffff;
			1: data = 32'sh80000000;
			default: data = word_t'($urandom());
		endcase
		send_access(kind, a, data);
	endtask

	task automatic run_random(int count);
		repeat (count) send_random_access();
	endtask

	task automatic test_directed_access();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_access(OP_READ,  10'd0,    32'sh0);
		send_access(OP_WRITE, 10'd1023, 32'sh7fffffff);
		send_access(OP_WRITE, 10'd0,    32'sh80000000);
		send_access(OP_READ,  10'd1023, 32'sh0);
		send_access(OP_READ,  10'd0,    32'sh12345678);
		send_access(OP_WRITE, 10'd16,   -32'sd1);
		send_access(OP_READ,  10'd31,   32'sh0);
		send_access(OP_WRITE, 10'd512,  32'sh0);
		// all slots taken: each further fault evicts in arrival order
		send_access(OP_READ,  10'd528,  32'sh0);
		send_access(OP_READ,  10'd0,    32'sh0);
		send_access(OP_READ,  10'd1023, 32'sh0);
		send_access(OP_WRITE, 10'd1008, 32'sh55555555);
		send_access(OP_WRITE, 10'd255,  32'shaaaaaaaa);
		send_access(OP_READ,  10'd255,  32'sh0);
		send_access(OP_READ,  10'd16,   32'sh0);
		send_access(OP_READ,  10'd512,  32'sh0);
		send_access(OP_WRITE, 10'd767,  32'sh00000001);
		send_access(OP_READ,  10'd1008, 32'sh0);
		send_access(OP_READ,  10'd767,  32'sh0);
		send_access(OP_READ,  10'd1,    32'sh0);
	endtask

	task automatic test_no_idling();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(200);
	endtask

	task automatic test_sender_idle();
		send_idle_pct  = 53;
		recv_stall_pct = 0;
		run_random(200);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 53;
		run_random(200);
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 15;
		recv_stall_pct = 15;
		run_random(200);
	endtask

	task automatic test_long_holdoff();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// hold the result channel while requests keep coming
		holdoff_left = 300;
		run_random(40);
	endtask

	task automatic test_drain_pause();
		send_idle_pct  = 0;
		recv_stall_pct = 30;
		run_random(20);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		run_random(20);
	endtask

	// Result channel: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			rsp_ch.ready <= 1'b0;
			holdoff_left = holdoff_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no access outstanding", $realtime);
			end else begin
				want = pending_results.pop_front();
				check_field("rdata", want.rdata, rsp_ch.rdata);
				check_field("fault", 32'(want.fault), 32'(rsp_ch.fault));
				check_field("replaced", 32'(want.replaced), 32'(rsp_ch.replaced));
				check_field("evicted_page", 32'(want.evicted_page),
					32'(rsp_ch.evicted_page));
			end
		end
	end

	// Watchdog: give up when no transaction moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.op      = OP_READ;
		req_ch.addr    = '0;
		req_ch.wdata   = '0;
		rsp_ch.ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		holdoff_left   = 0;
		mismatches     = 0;
		quiet_cycles   = 0;
		resident_cnt   = 0;
		oldest_slot    = 0;
		foreach (resident_tag[i])
			resident_tag[i] = '0;
		foreach (word_mirror[i])
			word_mirror[i] = '0;
		foreach (hot_page[i])
			hot_page[i] = page_t'($urandom());
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_access();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_long_holdoff();
		test_drain_pause();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
